>>> hdl/sorted_array_table_macros.svh
// Assertion macros for the sorted array table.
// No dependencies; the including module must provide clk and arst_n.
`ifndef SORTED_ARRAY_TABLE_MACROS_SVH
`define SORTED_ARRAY_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define SAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_array_table assertion failed");
`define SAT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_array_table assertion failed");
`else
`define SAT_ASSERT_IMP(lbl, ante, cons)
`define SAT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/sat_pkg.sv
// Shared types and constants for the sorted array table.
// No dependencies.
package sat_pkg;

	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] entry_count;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_STEP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DEL_RD,
		S_DEL_STEP
	} state_t;

	typedef enum logic [2:0] {
		RD_ADD_FIRST,
		RD_ADD_NEXT,
		RD_MID,
		RD_DEL_FIRST,
		RD_DEL_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_DEC,
		IDX_INC,
		IDX_MID
	} idx_op_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rsel;
		logic    mid_load;
		logic    we;
		logic    wsel_v;
		idx_op_t idx_op;
		logic    lo_up;
		logic    hx_dn;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    fin;
		status_t st;
		logic    pos_mid;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic idx_zero;
		logic idx_one;
		logic range_empty;
		logic eq;
		logic lt;
		logic del_last;
		logic del_more;
	} dp_stat_t;

endpackage

>>> hdl/sat_datapath.sv
// Datapath of the sorted array table: entry memory, count, search bounds and result register.
// Depends on sat_pkg.
module sat_datapath import sat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DATA_W-1:0] value,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic              done,
	output res_t              result
);

	logic [DATA_W-1:0] mem_q [CAPACITY];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  lo_q, hx_q;
	logic [ADDR_W-1:0] mid_q;
	logic [CNT_W:0]    mid_sum;
	logic [ADDR_W-1:0] mid_w;
	logic [CNT_W-1:0]  rd_full;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] wdata;
	logic [CNT_W:0]    idx_p1, idx_p2;
	logic              done_q;
	res_t              res_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CNT_W+1)'(1);
	assign mid_w   = mid_sum[CNT_W-1:1];
	assign idx_p1  = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2  = {1'b0, idx_q} + (CNT_W+1)'(2);

	always_comb begin
		case (cmd.rsel)
			RD_ADD_FIRST: rd_full = idx_q - CNT_W'(1);
			RD_ADD_NEXT:  rd_full = idx_q - CNT_W'(2);
			RD_MID:       rd_full = {1'b0, mid_w};
			RD_DEL_FIRST: rd_full = idx_p1[CNT_W-1:0];
			RD_DEL_NEXT:  rd_full = idx_p2[CNT_W-1:0];
			default:      rd_full = '0;
		endcase
	end

	assign rd_addr = rd_full[ADDR_W-1:0];
	assign wdata   = cmd.wsel_v ? value_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[idx_q[ADDR_W-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.cnt_inc) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			lo_q    <= '0;
			hx_q    <= count_q;
		end else begin
			if (cmd.lo_up) begin
				lo_q <= {1'b0, mid_q} + CNT_W'(1);
			end
			if (cmd.hx_dn) begin
				hx_q <= {1'b0, mid_q};
			end
		end
		if (cmd.mid_load) begin
			mid_q <= mid_w;
		end
		if (cmd.load) begin
			idx_q <= count_q;
		end else begin
			case (cmd.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_DEC:  idx_q <= idx_q - CNT_W'(1);
				IDX_INC:  idx_q <= idx_p1[CNT_W-1:0];
				IDX_MID:  idx_q <= {1'b0, mid_q};
				default:  idx_q <= idx_q;
			endcase
		end
		if (cmd.fin) begin
			res_q.status      <= cmd.st;
			res_q.position    <= cmd.pos_mid ? POS_W'(mid_q) : '0;
			res_q.entry_count <= count_d;
		end
	end

	assign stat.full        = (count_q == CNT_W'(CAPACITY));
	assign stat.idx_zero    = (idx_q == '0);
	assign stat.idx_one     = (idx_q == CNT_W'(1));
	assign stat.range_empty = (lo_q >= hx_q);
	assign stat.eq          = (rdata_q == value_q);
	assign stat.lt          = ($signed(value_q) < $signed(rdata_q));
	assign stat.del_last    = (idx_p1 >= {1'b0, count_q});
	assign stat.del_more    = (idx_p2 < {1'b0, count_q});

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> hdl/sat_controller.sv
// Controller of the sorted array table: sequences insert shifts, binary search and remove shifts.
// Depends on sat_pkg.
module sat_controller import sat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] op,
	input  dp_stat_t   stat,
	output logic       busy,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   remove_q, remove_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			remove_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			remove_q <= remove_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		remove_d = remove_q;
		cmd      = '0;
		cmd.rsel = RD_MID;
		cmd.st   = ST_OK;
		busy     = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					remove_d = (op == OP_REMOVE);
					if (op == OP_ADD) begin
						if (stat.full) begin
							cmd.fin = 1'b1;
							cmd.st  = ST_FULL;
						end else begin
							state_d = S_ADD_RD;
						end
					end else begin
						state_d = S_SRCH_RD;
					end
				end
			end
			S_ADD_RD: begin
				if (stat.idx_zero) begin
					cmd.we      = 1'b1;
					cmd.wsel_v  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.fin     = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rsel  = RD_ADD_FIRST;
					state_d   = S_ADD_STEP;
				end
			end
			S_ADD_STEP: begin
				if (stat.lt) begin
					cmd.we     = 1'b1;
					cmd.idx_op = IDX_DEC;
					if (stat.idx_one) begin
						state_d = S_ADD_RD;
					end else begin
						cmd.rd_en = 1'b1;
						cmd.rsel  = RD_ADD_NEXT;
					end
				end else begin
					cmd.we      = 1'b1;
					cmd.wsel_v  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.fin     = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SRCH_RD: begin
				if (stat.range_empty) begin
					cmd.fin = 1'b1;
					cmd.st  = ST_MISSING;
					state_d = S_IDLE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.rsel     = RD_MID;
					cmd.mid_load = 1'b1;
					state_d      = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.eq) begin
					if (remove_q) begin
						cmd.idx_op = IDX_MID;
						state_d    = S_DEL_RD;
					end else begin
						cmd.fin     = 1'b1;
						cmd.pos_mid = 1'b1;
						state_d     = S_IDLE;
					end
				end else if (stat.lt) begin
					cmd.hx_dn = 1'b1;
					state_d   = S_SRCH_RD;
				end else begin
					cmd.lo_up = 1'b1;
					state_d   = S_SRCH_RD;
				end
			end
			S_DEL_RD: begin
				if (stat.del_last) begin
					cmd.cnt_dec = 1'b1;
					cmd.fin     = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rsel  = RD_DEL_FIRST;
					state_d   = S_DEL_STEP;
				end
			end
			S_DEL_STEP: begin
				cmd.we     = 1'b1;
				cmd.idx_op = IDX_INC;
				if (stat.del_more) begin
					cmd.rd_en = 1'b1;
					cmd.rsel  = RD_DEL_NEXT;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.fin     = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/sorted_array_table.sv
// Sorted array table: one result per request, strobed on done.
// Add: ST_FULL when full; else each entry greater than the value is moved up, then the value is written.
// Search: binary search reading the middle entry on each probe, up to 6 probes; ST_MISSING on a miss.
// Remove: search, then each entry after the match is moved down one slot and the count decremented.
// One request at a time; busy drops in the strobe cycle, in which the next may be accepted.
// Reset clears the count and control; entry memory is not cleared.
module sorted_array_table import sat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t result
);

	`include "sorted_array_table_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sat_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	sat_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (req.value),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	`SAT_ASSERT_NXT(a_accept_busy, start && !busy && !cmd.fin, busy)
	`SAT_ASSERT_IMP(a_done_idle, done, !busy)
	`SAT_ASSERT_IMP(a_count_limit, done, result.entry_count <= CNT_W'(CAPACITY))
	`SAT_ASSERT_IMP(a_full_count, done && result.status == ST_FULL, result.entry_count == CNT_W'(CAPACITY))
	`SAT_ASSERT_IMP(a_missing_pos, done && result.status == ST_MISSING, result.position == '0)

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sorted array table: directed and random requests,
// every result compared field by field against a shadow copy of the table.
// Depends on sat_pkg and sorted_array_table.
module testbench;
	import sat_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PRINT_LIMIT = 20;
	localparam int         DRAIN_WAIT  = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	res_t result;

	logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
	int                       shadow_count = 0;
	res_t                     pending_results [$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	bit                       gaps_on = 1'b0;

	sorted_array_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic bit search_shadow(input logic signed [DATA_W-1:0] v, output int at);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = shadow_count - 1;
		at = 0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (shadow_vals[mid] == v) begin
				at = mid;
				return 1'b1;
			end else if (v < shadow_vals[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return 1'b0;
	endfunction

	function automatic res_t apply_request(input req_t r);
		res_t                     o;
		logic signed [DATA_W-1:0] v;
		int                       slot;
		int                       at;
		v = $signed(r.value);
		o.status = ST_OK;
		o.position = '0;
		case (r.op)
			OP_ADD: begin
				if (shadow_count >= CAPACITY) begin
					o.status = ST_FULL;
				end else begin
					slot = 0;
					while (slot < shadow_count && !(v < shadow_vals[slot]))
						slot++;
					for (int i = shadow_count; i > slot; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[slot] = v;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (search_shadow(v, at)) begin
					for (int i = at; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_vals[shadow_count-1] = '0;
					shadow_count--;
				end else begin
					o.status = ST_MISSING;
				end
			end
			default: begin
				if (search_shadow(v, at))
					o.position = POS_W'(at);
				else
					o.status = ST_MISSING;
			end
		endcase
		o.entry_count = CNT_W'(shadow_count);
		return o;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
		req_t r;
		r.op = op;
		r.value = value;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_request(r));
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, status", int'(result.status), 0);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					flag_mismatch("status", int'(result.status), int'(want.status));
				if (result.position !== want.position)
					flag_mismatch("position", int'(result.position), int'(want.position));
				if (result.entry_count !== want.entry_count)
					flag_mismatch("entry_count", int'(result.entry_count),
						int'(want.entry_count));
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4 && shadow_count > 0)
			return shadow_vals[$urandom_range(0, shadow_count - 1)];
		else if (k < 8)
			return DATA_W'(int'($urandom_range(0, 16)) - 8);
		else
			return $urandom;
	endfunction

	task automatic test_empty_table();
		send_request(OP_SEARCH, 32'd0);
		send_request(OP_REMOVE, 32'h8000_0000);
		send_request(OP_UNUSED, 32'd5);
	endtask

	task automatic test_ordering();
		send_request(OP_ADD, 32'd0);
		send_request(OP_ADD, 32'h7fff_ffff);
		send_request(OP_ADD, 32'h8000_0000);
		send_request(OP_ADD, 32'hffff_ffff);
		send_request(OP_ADD, 32'd0);
		send_request(OP_ADD, 32'd20);
		send_request(OP_SEARCH, 32'h8000_0000);
		send_request(OP_SEARCH, 32'h7fff_ffff);
		send_request(OP_SEARCH, 32'd0);
		send_request(OP_SEARCH, 32'hffff_ffff);
		send_request(OP_SEARCH, 32'd7);
		send_request(OP_UNUSED, 32'd20);
		send_request(OP_REMOVE, 32'd0);
		send_request(OP_REMOVE, 32'd0);
		send_request(OP_REMOVE, 32'd0);
		send_request(OP_REMOVE, 32'h7fff_ffff);
		send_request(OP_SEARCH, 32'd20);
		send_request(OP_REMOVE, 32'd21);
	endtask

	task automatic test_full_table();
		gaps_on = 1'b1;
		while (shadow_count < CAPACITY)
			send_request(OP_ADD, pick_value());
		send_request(OP_ADD, 32'h5a5a_a5a5);
		send_request(OP_SEARCH, shadow_vals[CAPACITY-1]);
		send_request(OP_SEARCH, shadow_vals[0]);
		send_request(OP_REMOVE, shadow_vals[CAPACITY/2]);
		send_request(OP_ADD, 32'h8000_0000);
		send_request(OP_ADD, 32'h7fff_ffff);
		while (shadow_count > 0)
			send_request(OP_REMOVE, shadow_vals[$urandom_range(0, shadow_count - 1)]);
		send_request(OP_REMOVE, 32'd1);
	endtask

	task automatic test_random_mix(input int total);
		int         add_pct;
		int         roll;
		int         sent;
		logic [1:0] op;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(0, 2))
				0: add_pct = 75;
				1: add_pct = 20;
				default: add_pct = 45;
			endcase
			gaps_on = (total - sent > 60) && ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(20, 60)) begin
				if (sent < total) begin
					roll = $urandom_range(0, 99);
					if (roll < add_pct)
						op = OP_ADD;
					else if (roll < add_pct + (100 - add_pct) / 2)
						op = OP_REMOVE;
					else if (roll < 97)
						op = OP_SEARCH;
					else
						op = OP_UNUSED;
					send_request(op, pick_value());
					sent++;
					if (total - sent <= 60)
						gaps_on = 1'b0;
				end
			end
		end
	endtask

	initial begin
		start <= 1'b0;
		req <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_ordering();
		test_full_table();
		test_random_mix(360);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sorted_array_table.f
+incdir+hdl
hdl/sat_pkg.sv
hdl/sat_datapath.sv
hdl/sat_controller.sv
hdl/sorted_array_table.sv
dv/testbench.sv
